[rtl/npcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types and constants for the nearest palette color search
// ----------------------------------------------------------------------------
package npcs_pkg;

	localparam int unsigned COLOR_W         = 8;
	localparam int unsigned IDX_W           = 8;
	localparam int unsigned RGB_W           = 3 * COLOR_W;
	localparam int unsigned SQ_W            = 2 * COLOR_W;
	// three squares of 255 fit in 18 bits
	localparam int unsigned DIST_W          = SQ_W + 2;
	localparam int unsigned PAL_ENTRIES_DEF = 256;
	localparam int unsigned QUEUE_DEPTH     = 2;

	// all ones is above the largest distance, so the first entry always wins
	localparam logic [DIST_W-1:0] DIST_START = '1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// classified command as it travels through the queue
	typedef struct packed {
		logic               is_query;
		logic               wr_ok;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic               skip;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

[rtl/npcs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module npcs_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/npcs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_front
// accepts command beats, classifies them and queues them for the scan engine
// ----------------------------------------------------------------------------
module npcs_front #(
	parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PAL_ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic                            opcode,
	input  wire logic [npcs_pkg::IDX_W-1:0]      entry_index,
	input  wire logic [npcs_pkg::COLOR_W-1:0]    red,
	input  wire logic [npcs_pkg::COLOR_W-1:0]    green,
	input  wire logic [npcs_pkg::COLOR_W-1:0]    blue,
	input  wire logic                            exclude_zero,
	input  wire logic                            pop,
	output npcs_pkg::cmd_t                       head,
	output npcs_pkg::q_stat_t                    stat
);
	import npcs_pkg::*;

	localparam int unsigned QW = $clog2(QUEUE_DEPTH);

	cmd_t        fifo_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   count_q;
	cmd_t        cmd;

	// writes past the palette are dropped at the back
	always_comb begin
		cmd.is_query = (opcode_t'(opcode) == OP_QUERY);
		cmd.wr_ok    = ({1'b0, entry_index} < (IDX_W+1)'(PALETTE_ENTRIES));
		cmd.idx      = entry_index;
		cmd.r        = red;
		cmd.g        = green;
		cmd.b        = blue;
		cmd.skip     = exclude_zero;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QW+1)'(1);
			end
		end
	end

	assign head       = fifo_q[rd_ptr_q];
	assign stat.full  = (count_q == (QW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule
`default_nettype wire

[rtl/npcs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_back
// palette store and pipelined nearest color scan
// ----------------------------------------------------------------------------
module npcs_back #(
	parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PAL_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  npcs_pkg::cmd_t                   head,
	input  wire logic                        head_valid,
	output logic                             pop,
	output logic                             done,
	output logic [npcs_pkg::IDX_W-1:0]       nearest_idx
);
	import npcs_pkg::*;

	localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t               state_q;
	logic [AW-1:0]        addr_q;
	logic [COLOR_W-1:0]   tgt_r_q, tgt_g_q, tgt_b_q;
	logic [PALETTE_ENTRIES-1:0] valid_q;

	logic                 we;
	logic [RGB_W-1:0]     rdata;

	logic                 v_s1, last_s1, vld_s1;
	logic [AW-1:0]        idx_s1;
	logic                 v_s2, last_s2;
	logic [AW-1:0]        idx_s2;
	logic [SQ_W-1:0]      sq_r_s2, sq_g_s2, sq_b_s2;
	logic                 v_s3, last_s3;
	logic [AW-1:0]        idx_s3;
	logic [DIST_W-1:0]    dist_s3;

	logic [DIST_W-1:0]    min_dist_q;
	logic [AW-1:0]        best_idx_q;
	logic                 done_q;
	logic [IDX_W-1:0]     nearest_idx_q;

	logic [RGB_W-1:0]     color;
	logic [COLOR_W-1:0]   d_r, d_g, d_b;
	logic                 take;
	logic                 at_last;

	function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign pop     = (state_q == ST_IDLE) && head_valid;
	assign we      = pop && !head.is_query && head.wr_ok;
	assign at_last = (addr_q == AW'(PALETTE_ENTRIES - 1));

	npcs_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (head.idx[AW-1:0]),
		.wdata ({head.r, head.g, head.b}),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// unwritten entries read as the grayscale ramp
	assign color = vld_s1 ? rdata : {3{COLOR_W'(idx_s1)}};
	assign d_r   = abs_diff(tgt_r_q, color[3*COLOR_W-1:2*COLOR_W]);
	assign d_g   = abs_diff(tgt_g_q, color[2*COLOR_W-1:COLOR_W]);
	assign d_b   = abs_diff(tgt_b_q, color[COLOR_W-1:0]);
	// strict less keeps the lowest index on ties
	assign take  = (dist_s3 < min_dist_q);

	always_ff @(posedge clk) begin
		if (pop && head.is_query) begin
			tgt_r_q <= head.r;
			tgt_g_q <= head.g;
			tgt_b_q <= head.b;
		end
		vld_s1  <= valid_q[addr_q];
		idx_s1  <= addr_q;
		last_s1 <= at_last;
		idx_s2  <= idx_s1;
		last_s2 <= last_s1;
		sq_r_s2 <= SQ_W'(d_r) * SQ_W'(d_r);
		sq_g_s2 <= SQ_W'(d_g) * SQ_W'(d_g);
		sq_b_s2 <= SQ_W'(d_b) * SQ_W'(d_b);
		idx_s3  <= idx_s2;
		last_s3 <= last_s2;
		dist_s3 <= DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);
		if (pop && head.is_query) begin
			min_dist_q <= DIST_START;
		end else if (v_s3 && take) begin
			min_dist_q <= dist_s3;
			best_idx_q <= idx_s3;
		end
		if (v_s3 && last_s3) begin
			nearest_idx_q <= take ? IDX_W'(idx_s3) : IDX_W'(best_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			valid_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (we) begin
				valid_q[head.idx[AW-1:0]] <= 1'b1;
			end
			v_s1   <= (state_q == ST_SCAN);
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3 && last_s3;
			case (state_q)
				ST_IDLE: begin
					if (pop && head.is_query) begin
						addr_q  <= head.skip ? AW'(1) : '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (at_last) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign nearest_idx = nearest_idx_q;

endmodule
`default_nettype wire

[rtl/nearest_palette_color_search_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// palette of rgb entries with a squared euclidean nearest color search
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  command   start / busy      opcode, entry_index, red, green, blue, exclude_zero
//  result    done (strobe)     nearest_idx
//
// - a command beat is taken when start is high and busy is low
// - writes go to the palette ram as they leave the queue; a query scans the
//   palette depth, less one entry with exclude_zero, at one palette ram read per
//   cycle and then drains the three stage distance pipeline
// - the result is a one cycle strobe on done; the receiver cannot stall it
// - busy rises only when the two entry command queue is full
// - after reset the palette reads as a grayscale ramp with entry zero black;
//   no clearing pass is needed, per entry valid bits pick ram or ramp value
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top #(
	parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PAL_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          opcode,
	input  wire logic [npcs_pkg::IDX_W-1:0]    entry_index,
	input  wire logic [npcs_pkg::COLOR_W-1:0]  red,
	input  wire logic [npcs_pkg::COLOR_W-1:0]  green,
	input  wire logic [npcs_pkg::COLOR_W-1:0]  blue,
	input  wire logic                          exclude_zero,
	output logic                               done,
	output logic [npcs_pkg::IDX_W-1:0]         nearest_idx
);
	import npcs_pkg::*;

	logic    push;
	logic    pop;
	cmd_t    head;
	q_stat_t q_stat;

	// accepted command beat
	assign push = start && !busy;
	assign busy = q_stat.full;

	// front: classify and queue
	npcs_front #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.opcode       (opcode),
		.entry_index  (entry_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.exclude_zero (exclude_zero),
		.pop          (pop),
		.head         (head),
		.stat         (q_stat)
	);

	// back: palette writes and scans, one queued command at a time
	npcs_back #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (!q_stat.empty),
		.pop         (pop),
		.done        (done),
		.nearest_idx (nearest_idx)
	);

	// queue status is never full and empty at once
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// an accepted beat leaves the queue non-empty
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("accepted beat lost from queue");

	// the back end never pops an empty queue
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// two scans cannot finish on adjacent cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobes back to back");

	// reported index lies inside the palette
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, nearest_idx} < (IDX_W+1)'(PALETTE_ENTRIES)))
		else $error("best index outside palette");

endmodule
`default_nettype wire

[tb/sv/tb_nearest_palette_color_search_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search_top
// self-checking bench for the nearest palette color search
// ----------------------------------------------------------------------------
// a short table of directed beats (grayscale ramp after reset, extreme colors,
// exclude_zero on and off, entry zero rewritten, equal distances) is followed
// by random palette writes and queries. a local palette copy predicts the index
// of each untyped query; results are matched in order on the done strobe.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search_top;
	import npcs_pkg::*;

	localparam int unsigned PAL_N        = PAL_ENTRIES_DEF;
	localparam int unsigned RANDOM_BEATS = 2000;
	// the limit covers a full palette scan and the longest sender gap
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned CALM_FIRST   = 600;
	localparam int unsigned CALM_LAST    = 900;

	// one command beat; typed rows carry their expected index
	typedef struct {
		opcode_t            op;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] r;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] b;
		logic               skip;
		bit                 typed;
		logic [IDX_W-1:0]   want;
	} palette_cmd_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [IDX_W-1:0]   entry_index;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               exclude_zero;
	logic               done;
	logic [IDX_W-1:0]   nearest_idx;

	// local copy of the palette, advanced on every accepted write beat
	logic [COLOR_W-1:0] pal_red   [PAL_N];
	logic [COLOR_W-1:0] pal_green [PAL_N];
	logic [COLOR_W-1:0] pal_blue  [PAL_N];

	palette_cmd_t       directed_cmds[$];
	logic [IDX_W-1:0]   expected_best[$];
	logic [IDX_W-1:0]   oldest_best;
	int unsigned        fail_count   = 0;
	int unsigned        quiet_cycles = 0;

	nearest_palette_color_search_top #(
		.PALETTE_ENTRIES(PAL_N)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.exclude_zero(exclude_zero),
		.done        (done),
		.nearest_idx (nearest_idx)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// palette predictor
	// ------------------------------------------------------------------------

	// grayscale ramp, entry zero black
	task automatic load_gray_ramp();
		int unsigned i;
		for (i = 0; i < PAL_N; i++) begin
			pal_red[i]   = i[COLOR_W-1:0];
			pal_green[i] = i[COLOR_W-1:0];
			pal_blue[i]  = i[COLOR_W-1:0];
		end
	endtask

	function automatic int unsigned channel_sq(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
		int unsigned ua;
		int unsigned ub;
		int unsigned d;
		ua = 32'(a);
		ub = 32'(b);
		d  = (ua >= ub) ? ua - ub : ub - ua;
		return d * d;
	endfunction

	// lowest index with the least squared distance; strict less keeps ties low
	function automatic logic [IDX_W-1:0] nearest_entry(logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b, logic skip);
		int unsigned i;
		int unsigned first;
		int unsigned best;
		int unsigned least_sq;
		int unsigned sq_sum;
		first    = skip ? 1 : 0;
		best     = first;
		least_sq = 32'h7FFF_FFFF;
		for (i = first; i < PAL_N; i++) begin
			sq_sum = channel_sq(r, pal_red[i]) + channel_sq(g, pal_green[i])
				+ channel_sq(b, pal_blue[i]);
			if (sq_sum < least_sq) begin
				least_sq = sq_sum;
				best     = i;
			end
		end
		return best[IDX_W-1:0];
	endfunction

	// book an accepted beat: writes update the palette copy, queries queue
	// the index they must return
	task automatic book_beat(palette_cmd_t c);
		if (c.op == OP_WRITE) begin
			// writes past the palette end are dropped by the block
			if (c.idx < PAL_N) begin
				pal_red[c.idx]   = c.r;
				pal_green[c.idx] = c.g;
				pal_blue[c.idx]  = c.b;
			end
		end else begin
			expected_best.push_back(c.typed ? c.want : nearest_entry(c.r, c.g, c.b, c.skip));
		end
	endtask

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	task automatic add_write(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
		palette_cmd_t c;
		c.op    = OP_WRITE;
		c.idx   = idx;
		c.r     = r;
		c.g     = g;
		c.b     = b;
		c.skip  = 1'b0;
		c.typed = 1'b0;
		c.want  = '0;
		directed_cmds.push_back(c);
	endtask

	task automatic add_query(logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] r,
			logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b, logic skip,
			bit typed, logic [IDX_W-1:0] want);
		palette_cmd_t c;
		c.op    = OP_QUERY;
		c.idx   = idx;
		c.r     = r;
		c.g     = g;
		c.b     = b;
		c.skip  = skip;
		c.typed = typed;
		c.want  = want;
		directed_cmds.push_back(c);
	endtask

	// a color a few steps off a stored one, clamped to the channel range
	function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] v);
		int n;
		n = int'(v) + int'($urandom_range(6)) - 3;
		if (n < 0)
			n = 0;
		if (n > 255)
			n = 255;
		return n[COLOR_W-1:0];
	endfunction

	function automatic logic [COLOR_W-1:0] rail();
		return $urandom_range(1) ? 8'hFF : 8'h00;
	endfunction

	function automatic palette_cmd_t random_cmd();
		palette_cmd_t c;
		int unsigned  pick;
		int unsigned  k;
		c.op    = $urandom_range(1) ? OP_QUERY : OP_WRITE;
		c.idx   = IDX_W'($urandom_range(255));
		c.skip  = 1'($urandom_range(1));
		c.typed = 1'b0;
		c.want  = '0;
		c.r     = COLOR_W'($urandom_range(255));
		c.g     = COLOR_W'($urandom_range(255));
		c.b     = COLOR_W'($urandom_range(255));
		// entry zero gets extra weight so exclude_zero has something to exclude
		k    = ($urandom_range(9) == 0) ? 0 : $urandom_range(PAL_N - 1);
		pick = $urandom_range(99);
		if (c.op == OP_WRITE) begin
			if (pick < 5) begin
				c.idx = '0;
			end else if (pick < 25) begin
				// duplicate an existing color to set up equal distances
				c.r = pal_red[k];
				c.g = pal_green[k];
				c.b = pal_blue[k];
			end else if (pick < 35) begin
				c.r = rail();
				c.g = rail();
				c.b = rail();
			end
		end else begin
			if (pick < 40) begin
				c.r = nudge(pal_red[k]);
				c.g = nudge(pal_green[k]);
				c.b = nudge(pal_blue[k]);
			end else if (pick < 50) begin
				c.r = rail();
				c.g = rail();
				c.b = rail();
			end
		end
		return c;
	endfunction

	// sender idles before about 38 of 100 beats; now and then a long gap
	// so that new beats land at every point of a running scan
	function automatic int unsigned sender_gap(bit calm);
		if (calm || $urandom_range(99) >= 38)
			return 0;
		if ($urandom_range(7) == 0)
			return $urandom_range(300, 1);
		return $urandom_range(4, 1);
	endfunction

	// called at a rising edge; returns at the edge that takes the beat, or
	// after the idle gap that follows it
	task automatic send_cmd(palette_cmd_t c, int unsigned gap);
		start        <= 1'b1;
		opcode       <= c.op;
		entry_index  <= c.idx;
		red          <= c.r;
		green        <= c.g;
		blue         <= c.b;
		exclude_zero <= c.skip;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		book_beat(c);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// result check and watchdog
	// ------------------------------------------------------------------------

	// values read here are the ones present before the edge, so the dut's
	// own updates at this edge cannot race the check
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_best.size() == 0) begin
					$error("unexpected result: nearest_idx %0d", nearest_idx);
					fail_count++;
				end else begin
					oldest_best = expected_best.pop_front();
					if (nearest_idx !== oldest_best) begin
						$error("nearest_idx mismatch: expected %0d, actual %0d",
							oldest_best, nearest_idx);
						fail_count++;
					end
				end
			end
			// any beat taken on either side counts as progress
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** nearest_palette_color_search_top: FAILED **");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned n;
		arst_n       <= 1'b0;
		start        <= 1'b0;
		opcode       <= OP_WRITE;
		entry_index  <= '0;
		red          <= '0;
		green        <= '0;
		blue         <= '0;
		exclude_zero <= 1'b0;
		load_gray_ramp();

		// reset ramp: black at zero, each gray matches its own index
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0);
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd1);
		add_query(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd255);
		add_query(8'd0,   8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 8'd128);
		// saturated primaries against the gray ramp
		add_query(8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 1'b0, 8'd0);
		add_query(8'd255, 8'd0,   8'd255, 8'd0,   1'b1, 1'b0, 8'd0);
		// entry zero rewritten; exclude_zero must hide it again
		add_write(8'd0,   8'd255, 8'd0,   8'd0);
		add_query(8'd0,   8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 8'd0);
		add_query(8'd0,   8'd255, 8'd0,   8'd0,   1'b1, 1'b0, 8'd0);
		// exact black far up the palette beats the near gray at entry one
		add_write(8'd200, 8'd0,   8'd0,   8'd0);
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd200);
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd200);
		// equal distances: the lower index wins
		add_write(8'd10,  8'd50,  8'd60,  8'd70);
		add_write(8'd20,  8'd50,  8'd60,  8'd70);
		add_query(8'd0,   8'd50,  8'd60,  8'd70,  1'b0, 1'b1, 8'd10);
		// top entry moved away, white now falls to its neighbor
		add_write(8'd255, 8'd17,  8'd34,  8'd51);
		add_query(8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 8'd254);
		// entry zero black again ties with entry 200
		add_write(8'd0,   8'd0,   8'd0,   8'd0);
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 8'd0);
		add_query(8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 8'd200);
		// first visited entry of a skipping scan is the exact match
		add_write(8'd1,   8'd255, 8'd255, 8'd255);
		add_query(8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 8'd1);
		add_query(8'd255, 8'd1,   8'd2,   8'd3,   1'b1, 1'b0, 8'd0);
		add_write(8'd128, 8'd0,   8'd0,   8'd255);
		add_query(8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b1, 8'd128);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_cmds[i])
			send_cmd(directed_cmds[i], sender_gap(1'b0));
		// a stretch with no sender gaps keeps the command queue full
		for (n = 0; n < RANDOM_BEATS; n++)
			send_cmd(random_cmd(), sender_gap(n >= CALM_FIRST && n < CALM_LAST));
		start <= 1'b0;

		// the watchdog bounds this wait
		while (expected_best.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("** nearest_palette_color_search_top: PASSED **");
		else
			$display("** nearest_palette_color_search_top: FAILED **");
		$finish;
	end

endmodule

[files.f]
rtl/npcs_pkg.sv
rtl/npcs_ram.sv
rtl/npcs_front.sv
rtl/npcs_back.sv
rtl/nearest_palette_color_search_top.sv
tb/sv/tb_nearest_palette_color_search_top.sv
